// File: hdl/tvs_pkg.sv
// ----------------------------------------------------------------------------
// tvs_pkg
// Types and codes shared by the tagged varint serializer.
// ----------------------------------------------------------------------------
package tvs_pkg;

  localparam int MaxBytes  = 10;
  localparam int CntWidth  = $clog2(MaxBytes + 1);

  localparam logic [2:0] FUNC_CHAR   = 3'd0;
  localparam logic [2:0] FUNC_BOOL   = 3'd1;
  localparam logic [2:0] FUNC_INT    = 3'd2;
  localparam logic [2:0] FUNC_SHORT  = 3'd3;
  localparam logic [2:0] FUNC_LONG   = 3'd4;
  localparam logic [2:0] FUNC_STRHDR = 3'd5;
  localparam logic [2:0] FUNC_RAW    = 3'd6;

  localparam logic [7:0] TAG_CHAR   = 8'h63; // 'c'
  localparam logic [7:0] TAG_TRUE   = 8'h74; // 't'
  localparam logic [7:0] TAG_FALSE  = 8'h66; // 'f'
  localparam logic [7:0] TAG_INT    = 8'h69; // 'i'
  localparam logic [7:0] TAG_SHORT  = 8'h73; // 's'
  localparam logic [7:0] TAG_LONG   = 8'h6c; // 'l'
  localparam logic [7:0] TAG_STRHDR = 8'h53; // 'S'

  typedef struct packed {
    logic [2:0]         func;
    logic signed [63:0] value;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } result_t;

endpackage

// File: hdl/tagged_varint_serializer_core.sv
// ----------------------------------------------------------------------------
// tagged_varint_serializer_core
// Serializes one typed value per transaction into tagged varint bytes.
// ----------------------------------------------------------------------------
// An item is taken into an input register, encoded combinationally into a
// byte buffer of up to ten bytes, and the buffer sends one byte per cycle
// with result_valid high and last marking the item's final byte. An item has
// as many bytes as its kind needs (1 for bool and raw byte, 2 for char, 2 to
// 10 for integers and string headers), all on the single output byte lane; an
// undefined kind emits nothing but still leaves a gap on the output.
// The next item is encoded while the current last byte goes out, so bytes of
// consecutive items follow with no gap. The receiver cannot stall: every byte
// must be taken in the cycle it appears.
module tagged_varint_serializer_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  tvs_pkg::item_t   item,
  output logic             result_valid,
  output tvs_pkg::result_t result
);
  import tvs_pkg::*;

  logic                in_valid;
  item_t               in_q;
  logic [7:0]          buf_q [MaxBytes];
  logic [CntWidth-1:0] cnt;

  logic [7:0]          enc_buf [MaxBytes];
  logic [CntWidth-1:0] enc_cnt;
  logic signed [63:0]  sv;
  logic [71:0]         ext;
  logic [63:0]         mag;
  logic [7:0]          fits;
  logic [3:0]          len;
  logic [7:0]          ext_byte [9];
  logic                load;
  logic                accept;

  assign load   = in_valid && (cnt <= CntWidth'(1));
  assign busy   = in_valid && !load;
  assign accept = start && !busy;

  always_comb begin
    unique case (in_q.func)
      FUNC_SHORT: sv = {{48{in_q.value[15]}}, in_q.value[15:0]};
      FUNC_LONG:  sv = in_q.value;
      default:    sv = {{32{in_q.value[31]}}, in_q.value[31:0]};
    endcase
  end

  assign ext = {{8{sv[63]}}, sv};
  assign mag = sv[63] ? ~sv : sv;

  always_comb begin
    for (int l = 0; l < 8; l++) begin
      fits[l] = (mag >> (8 * l + 3)) == 64'd0;
    end
    len = 4'd8;
    for (int l = 7; l >= 0; l--) begin
      if (fits[l]) begin
        len = 4'(l);
      end
    end
    for (int b = 0; b < 9; b++) begin
      ext_byte[b] = ext[8 * b +: 8];
    end
  end

  always_comb begin
    logic [3:0] idx;
    idx = 4'd0;
    for (int i = 0; i < MaxBytes; i++) begin
      enc_buf[i] = 8'h00;
    end
    enc_cnt = '0;
    case (in_q.func)
      FUNC_CHAR: begin
        enc_buf[0] = TAG_CHAR;
        enc_buf[1] = in_q.value[7:0];
        enc_cnt    = CntWidth'(2);
      end
      FUNC_BOOL: begin
        enc_buf[0] = (in_q.value != 64'sd0) ? TAG_TRUE : TAG_FALSE;
        enc_cnt    = CntWidth'(1);
      end
      FUNC_RAW: begin
        enc_buf[0] = in_q.value[7:0];
        enc_cnt    = CntWidth'(1);
      end
      FUNC_INT, FUNC_SHORT, FUNC_LONG, FUNC_STRHDR: begin
        case (in_q.func)
          FUNC_SHORT: enc_buf[0] = TAG_SHORT;
          FUNC_LONG:  enc_buf[0] = TAG_LONG;
          FUNC_INT:   enc_buf[0] = TAG_INT;
          default:    enc_buf[0] = TAG_STRHDR;
        endcase
        enc_buf[1] = {len, ext[8 * len +: 4]};
        for (int j = 0; j < 8; j++) begin
          idx = len - 4'(j) - 4'd1;
          if (4'(j) < len) begin
            enc_buf[2 + j] = ext_byte[idx];
          end
        end
        enc_cnt = CntWidth'(len) + CntWidth'(2);
      end
      default: enc_cnt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      cnt      <= '0;
    end else begin
      if (accept) begin
        in_valid <= 1'b1;
      end else if (load) begin
        in_valid <= 1'b0;
      end
      if (load) begin
        cnt <= enc_cnt;
      end else if (cnt != '0) begin
        cnt <= cnt - CntWidth'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= item;
    end
    if (load) begin
      buf_q <= enc_buf;
    end else begin
      for (int i = 0; i < MaxBytes - 1; i++) begin
        buf_q[i] <= buf_q[i + 1];
      end
    end
  end

  assign result_valid    = (cnt != '0);
  assign result.out_byte = buf_q[0];
  assign result.last     = (cnt == CntWidth'(1));

  a_busy_needs_item: assert property (@(posedge clk) disable iff (rst)
    busy |-> in_valid)
    else $error("busy without a pending item");

  a_accept_holds: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> in_valid)
    else $error("accepted transaction lost");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |=> result_valid)
    else $error("gap inside a transaction's bytes");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last && !in_valid) |=> !result_valid)
    else $error("byte emitted with no transaction pending");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CntWidth'(MaxBytes))
    else $error("byte count overflow");

endmodule
